/* hw/rtl/bmhe_pkg.sv */
// shared types and constants of the bounded min-heap evicting unit
`default_nettype none
package bmhe_pkg;

	localparam int DEPTH_DEF    = 64;
	localparam int KEY_BITS_DEF = 64;
	localparam int TAG_W        = 32;
	localparam int KEY_W        = 64;
	localparam int OP_W         = 2;
	localparam int CAP_W        = 7;
	localparam int CNT_OUT_W    = 7;
	localparam int CAP_RESET    = 64;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_START,
		CMD_RD_ROOT,
		CMD_REJECT,
		CMD_TAKE_ROOT,
		CMD_TAKE_LAST,
		CMD_DN_L,
		CMD_DN_R,
		CMD_DN_C,
		CMD_PUSH,
		CMD_UP_I,
		CMD_UP_C,
		CMD_EMIT
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t cmd;
	} ctrl_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic reject;
		logic dn_leaf;
		logic dn_move;
		logic up_top;
		logic up_move;
		logic out_busy;
	} dp_status_t;

endpackage
`default_nettype wire

/* hw/rtl/bounded_min_heap_evicting_unit.sv */
// top level of the bounded min-heap evicting unit: ports, config register, wiring
`default_nettype none
// Bounded binary min-heap of up to capacity_limit entries (1..DEPTH; 0 acts as 1),
// ordered by an unsigned key with a 32-bit tag carried along. One item is taken
// at a time and gives exactly one result item. Entries live in a single ram with
// one write and one registered read per cycle, so each heap level costs memory
// round trips: sift-up reads the parent, then compares and writes; sift-down reads
// the left child, reads the right child, then compares and writes. A bounced
// insert only reads the root; an evicting insert is a pop followed by an insert
// (with further entries drained if capacity was lowered below the count); clear,
// unused codes and a pop from an empty heap go straight to the result. The result
// waits in an output register, so the next item's work overlaps a stalled
// consumer; an item only stalls when the previous result is still held at the
// moment its own result is ready.
// There is no clearing pass after reset; a clear only zeroes the count.
module bounded_min_heap_evicting_unit #(
	parameter int DEPTH    = bmhe_pkg::DEPTH_DEF,
	parameter int KEY_BITS = bmhe_pkg::KEY_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input item stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [95:0]  s_tdata,  // entry_tag[31:0], entry_key[95:32]
	input  wire logic [1:0]   s_tuser,  // operation[1:0]
	// result item stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [103:0] m_tdata,  // removed_tag[31:0], removed_key[95:32],
	                                    // entry_count[102:96], zero pad[103]
	output logic      [0:0]   m_tuser,  // removed_valid[0]
	// configuration port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready
);
	import bmhe_pkg::*;

	localparam logic [2:0] ADDR_CAP = 3'd0;

	ctrl_cmd_t            ctl;
	dp_status_t           sts;
	logic [CAP_W-1:0]     cap_q;
	logic                 out_flag;
	logic [TAG_W-1:0]     out_tag;
	logic [KEY_W-1:0]     out_key;
	logic [CNT_OUT_W-1:0] out_cnt;

	// capacity register, written on the access phase
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(CAP_RESET);
		end else if (psel && penable && pwrite && paddr == ADDR_CAP) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end
	assign prdata = (paddr == ADDR_CAP) ? 32'(cap_q) : 32'd0;

	// sequencer
	bmhe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.ctl      (ctl),
		.sts      (sts)
	);

	// heap storage and arithmetic
	bmhe_dp #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cap       (cap_q),
		.in_op     (s_tuser),
		.in_tag    (s_tdata[31:0]),
		.in_key    (s_tdata[95:32]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_flag  (out_flag),
		.out_tag   (out_tag),
		.out_key   (out_key),
		.out_cnt   (out_cnt)
	);

	// pack the result item
	assign m_tdata = {1'b0, out_cnt, out_key, out_tag};
	assign m_tuser = out_flag;
endmodule
`default_nettype wire

/* hw/rtl/bmhe_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module bmhe_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/bmhe_dp.sv */
// heap datapath: entry ram, moving entry, hole index, count, result and output registers
`default_nettype none
module bmhe_dp #(
	parameter int DEPTH    = bmhe_pkg::DEPTH_DEF,
	parameter int KEY_BITS = bmhe_pkg::KEY_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire bmhe_pkg::ctrl_cmd_t               ctl,
	output bmhe_pkg::dp_status_t                   sts,
	input  wire logic [bmhe_pkg::CAP_W-1:0]        cap,
	input  wire logic [bmhe_pkg::OP_W-1:0]         in_op,
	input  wire logic [bmhe_pkg::TAG_W-1:0]        in_tag,
	input  wire logic [bmhe_pkg::KEY_W-1:0]        in_key,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   out_flag,
	output logic      [bmhe_pkg::TAG_W-1:0]        out_tag,
	output logic      [bmhe_pkg::KEY_W-1:0]        out_key,
	output logic      [bmhe_pkg::CNT_OUT_W-1:0]    out_cnt
);
	import bmhe_pkg::*;

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int CHW = AW + 2;
	localparam int EW  = KEY_BITS + TAG_W;

	logic [KEY_BITS-1:0] in_key_q, mv_key_q, lft_key_q, res_key_q;
	logic [TAG_W-1:0]    in_tag_q, mv_tag_q, lft_tag_q, res_tag_q;
	logic                res_valid_q;
	logic [AW-1:0]       idx_q;
	logic [CW-1:0]       cnt_q;
	logic                out_valid_q, out_flag_q;
	logic [TAG_W-1:0]    out_tag_q;
	logic [KEY_W-1:0]    out_key_q;
	logic [CNT_OUT_W-1:0] out_cnt_q;

	logic           we;
	logic [AW-1:0]  waddr, raddr;
	logic [EW-1:0]  wdata, rdata;
	logic [KEY_BITS-1:0] rd_key, pick_key;
	logic [TAG_W-1:0]    rd_tag, pick_tag;
	logic [CHW-1:0] left_w, right_w, cnt_w;
	logic [AW-1:0]  parent, pick_idx;
	logic           use_right;
	logic [31:0]    cap_ext, ecap;

	bmhe_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_key  = rdata[KEY_BITS-1:0];
	assign rd_tag  = rdata[EW-1:KEY_BITS];
	assign cnt_w   = CHW'(cnt_q);
	assign left_w  = CHW'({idx_q, 1'b1});
	assign right_w = left_w + CHW'(1);
	assign parent  = (idx_q - AW'(1)) >> 1;

	// right child wins only when present and strictly smaller
	assign use_right = (right_w < cnt_w) && (lft_key_q > rd_key);
	assign pick_key  = use_right ? rd_key : lft_key_q;
	assign pick_tag  = use_right ? rd_tag : lft_tag_q;
	assign pick_idx  = use_right ? right_w[AW-1:0] : left_w[AW-1:0];

	assign cap_ext = 32'(cap);
	assign ecap    = (cap_ext == 32'd0) ? 32'd1 :
	                 ((cap_ext > 32'(DEPTH)) ? 32'(DEPTH) : cap_ext);

	always_comb begin
		sts.full     = 32'(cnt_q) >= ecap;
		sts.empty    = cnt_q == '0;
		sts.reject   = rd_key > in_key_q;
		sts.dn_leaf  = left_w >= cnt_w;
		sts.dn_move  = pick_key < mv_key_q;
		sts.up_top   = idx_q == '0;
		sts.up_move  = mv_key_q < rd_key;
		sts.out_busy = out_valid_q && !out_ready;
	end

	// ram port selection
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = {mv_tag_q, mv_key_q};
		raddr = '0;
		case (ctl.cmd)
			CMD_TAKE_ROOT: raddr = AW'(cnt_q - CW'(1));
			CMD_DN_L: begin
				if (sts.dn_leaf) begin
					we = 1'b1;
				end else begin
					raddr = left_w[AW-1:0];
				end
			end
			CMD_DN_R: raddr = right_w[AW-1:0];
			CMD_DN_C: begin
				we = 1'b1;
				if (sts.dn_move) begin
					wdata = {pick_tag, pick_key};
				end
			end
			CMD_UP_I: begin
				if (sts.up_top) begin
					we = 1'b1;
				end else begin
					raddr = parent;
				end
			end
			CMD_UP_C: begin
				we = 1'b1;
				if (sts.up_move) begin
					wdata = rdata;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (ctl.cmd)
				CMD_START: begin
					res_valid_q <= 1'b0;
					if (in_op == OP_CLEAR) begin
						cnt_q <= '0;
					end
				end
				CMD_REJECT:    res_valid_q <= 1'b1;
				CMD_TAKE_ROOT: res_valid_q <= 1'b1;
				CMD_TAKE_LAST: cnt_q <= cnt_q - CW'(1);
				CMD_UP_I: begin
					if (sts.up_top) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				CMD_UP_C: begin
					if (!sts.up_move) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				CMD_EMIT: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_START: begin
				in_key_q  <= in_key[KEY_BITS-1:0];
				in_tag_q  <= in_tag;
				mv_key_q  <= in_key[KEY_BITS-1:0];
				mv_tag_q  <= in_tag;
				idx_q     <= AW'(cnt_q);
				res_key_q <= '0;
				res_tag_q <= '0;
			end
			CMD_REJECT: begin
				res_key_q <= in_key_q;
				res_tag_q <= in_tag_q;
			end
			CMD_TAKE_ROOT: begin
				// only the first pop of an item is reported
				if (!res_valid_q) begin
					res_key_q <= rd_key;
					res_tag_q <= rd_tag;
				end
			end
			CMD_TAKE_LAST: begin
				mv_key_q <= rd_key;
				mv_tag_q <= rd_tag;
				idx_q    <= '0;
			end
			CMD_DN_R: begin
				lft_key_q <= rd_key;
				lft_tag_q <= rd_tag;
			end
			CMD_DN_C: begin
				if (sts.dn_move) begin
					idx_q <= pick_idx;
				end
			end
			CMD_PUSH: begin
				mv_key_q <= in_key_q;
				mv_tag_q <= in_tag_q;
				idx_q    <= AW'(cnt_q);
			end
			CMD_UP_C: begin
				if (sts.up_move) begin
					idx_q <= parent;
				end
			end
			CMD_EMIT: begin
				out_flag_q <= res_valid_q;
				out_tag_q  <= res_tag_q;
				out_key_q  <= KEY_W'(res_key_q);
				out_cnt_q  <= CNT_OUT_W'(cnt_q);
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_flag  = out_flag_q;
	assign out_tag   = out_tag_q;
	assign out_key   = out_key_q;
	assign out_cnt   = out_cnt_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(DEPTH))
		else $error("entry count above depth");
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.cmd == CMD_EMIT && !res_valid_q) |-> (res_key_q == '0 && res_tag_q == '0))
		else $error("empty result carries data");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cmd == CMD_TAKE_LAST |-> cnt_q != '0)
		else $error("pop from empty heap");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cmd == CMD_PUSH |-> 32'(cnt_q) < 32'(DEPTH))
		else $error("push into full storage");
endmodule
`default_nettype wire

/* hw/rtl/bmhe_ctrl.sv */
// heap sequencer: one-hot state machine issuing datapath commands
`default_nettype none
module bmhe_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [bmhe_pkg::OP_W-1:0] in_op,
	output bmhe_pkg::ctrl_cmd_t            ctl,
	input  wire bmhe_pkg::dp_status_t      sts
);
	import bmhe_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE     = 13'b0000000000001,
		ST_FULL_RD  = 13'b0000000000010,
		ST_FULL_CHK = 13'b0000000000100,
		ST_POP_RD   = 13'b0000000001000,
		ST_POP_ROOT = 13'b0000000010000,
		ST_POP_LAST = 13'b0000000100000,
		ST_DN_L     = 13'b0000001000000,
		ST_DN_R     = 13'b0000010000000,
		ST_DN_C     = 13'b0000100000000,
		ST_SIFT_END = 13'b0001000000000,
		ST_UP_I     = 13'b0010000000000,
		ST_UP_C     = 13'b0100000000000,
		ST_DONE     = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   ins_q, ins_d;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		state_d = state_q;
		ins_d   = ins_q;
		ctl.cmd = CMD_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.cmd = CMD_START;
					ins_d   = 1'b0;
					case (in_op)
						OP_INSERT: begin
							ins_d   = 1'b1;
							state_d = sts.full ? ST_FULL_RD : ST_UP_I;
						end
						OP_POP:  state_d = sts.empty ? ST_DONE : ST_POP_RD;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_FULL_RD: begin
				ctl.cmd = CMD_RD_ROOT;
				state_d = ST_FULL_CHK;
			end
			ST_FULL_CHK: begin
				if (sts.reject) begin
					ctl.cmd = CMD_REJECT;
					state_d = ST_DONE;
				end else begin
					ctl.cmd = CMD_TAKE_ROOT;
					state_d = ST_POP_LAST;
				end
			end
			ST_POP_RD: begin
				ctl.cmd = CMD_RD_ROOT;
				state_d = ST_POP_ROOT;
			end
			ST_POP_ROOT: begin
				ctl.cmd = CMD_TAKE_ROOT;
				state_d = ST_POP_LAST;
			end
			ST_POP_LAST: begin
				ctl.cmd = CMD_TAKE_LAST;
				state_d = ST_DN_L;
			end
			ST_DN_L: begin
				ctl.cmd = CMD_DN_L;
				state_d = sts.dn_leaf ? ST_SIFT_END : ST_DN_R;
			end
			ST_DN_R: begin
				ctl.cmd = CMD_DN_R;
				state_d = ST_DN_C;
			end
			ST_DN_C: begin
				ctl.cmd = CMD_DN_C;
				state_d = sts.dn_move ? ST_DN_L : ST_SIFT_END;
			end
			ST_SIFT_END: begin
				if (!ins_q) begin
					state_d = ST_DONE;
				end else if (sts.full) begin
					state_d = ST_POP_RD;
				end else begin
					ctl.cmd = CMD_PUSH;
					state_d = ST_UP_I;
				end
			end
			ST_UP_I: begin
				ctl.cmd = CMD_UP_I;
				state_d = sts.up_top ? ST_DONE : ST_UP_C;
			end
			ST_UP_C: begin
				ctl.cmd = CMD_UP_C;
				state_d = sts.up_move ? ST_UP_I : ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					ctl.cmd = CMD_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ins_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ins_q   <= ins_d;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cmd == CMD_EMIT |-> !sts.out_busy)
		else $error("result emitted over a pending item");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cmd == CMD_START |=> state_q != ST_IDLE)
		else $error("accepted item produced no work");
	a_push_after_sift: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cmd == CMD_PUSH |-> ins_q)
		else $error("push outside an insert");
endmodule
`default_nettype wire

/* test/testbench.sv */
// self-checking testbench for the bounded min-heap evicting unit
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import bmhe_pkg::*;

	localparam int HEAP_DEPTH = 64;
	localparam logic [2:0] ADDR_CAPACITY = 3'd0;
	// unused operation code, not in the package enum
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [95:0]  s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;
	logic [0:0]   m_tuser;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	bounded_min_heap_evicting_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// one result item as the heap reports it
	typedef struct packed {
		logic        removed_valid;
		logic [31:0] removed_tag;
		logic [63:0] removed_key;
		logic [6:0]  entry_count;
	} removal_t;

	// predictor state: shadow heap and capacity register
	logic [63:0] heap_key_q [HEAP_DEPTH];
	logic [31:0] heap_tag_q [HEAP_DEPTH];
	int          heap_used;
	logic [6:0]  capacity_reg;

	removal_t pending_removals [$];
	int       mismatch_count;
	int       result_count;
	int       item_count;
	bit       stall_enable;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic int eff_capacity();
		int c;
		c = capacity_reg;
		if (c == 0) c = 1;
		if (c > HEAP_DEPTH) c = HEAP_DEPTH;
		return c;
	endfunction

	function automatic void swap_entries(int a, int b);
		logic [63:0] k;
		logic [31:0] t;
		k = heap_key_q[a]; t = heap_tag_q[a];
		heap_key_q[a] = heap_key_q[b]; heap_tag_q[a] = heap_tag_q[b];
		heap_key_q[b] = k; heap_tag_q[b] = t;
	endfunction

	// remove the root, move the last entry up top and sift it down
	function automatic void take_root(output logic [63:0] key, output logic [31:0] tag);
		int parent, left, pick;
		parent = 0;
		key = heap_key_q[0];
		tag = heap_tag_q[0];
		heap_used--;
		heap_key_q[0] = heap_key_q[heap_used];
		heap_tag_q[0] = heap_tag_q[heap_used];
		heap_key_q[heap_used] = '0;
		heap_tag_q[heap_used] = '0;
		forever begin
			left = 2 * parent + 1;
			if (left >= heap_used) break;
			pick = left;
			// ties go to the left child
			if (left + 1 < heap_used && heap_key_q[left] > heap_key_q[left + 1])
				pick = left + 1;
			if (heap_key_q[pick] < heap_key_q[parent]) begin
				swap_entries(parent, pick);
				parent = pick;
			end else begin
				break;
			end
		end
	endfunction

	function automatic void add_entry(logic [63:0] key, logic [31:0] tag);
		int cur, par;
		cur = heap_used;
		heap_key_q[cur] = key;
		heap_tag_q[cur] = tag;
		while (cur > 0) begin
			par = (cur - 1) / 2;
			if (heap_key_q[cur] < heap_key_q[par]) begin
				swap_entries(cur, par);
				cur = par;
			end else begin
				break;
			end
		end
		heap_used++;
	endfunction

	function automatic removal_t predict_removal(logic [1:0] op, logic [31:0] tag,
			logic [63:0] key);
		removal_t r;
		logic [63:0] dk;
		logic [31:0] dt;
		int cap;
		bit inserting;
		r = '0;
		case (op)
			OP_INSERT: begin
				cap = eff_capacity();
				inserting = 1'b1;
				if (heap_used >= cap) begin
					r.removed_valid = 1'b1;
					if (heap_key_q[0] > key) begin
						// newcomer is older than the root: bounce it
						r.removed_key = key;
						r.removed_tag = tag;
						inserting = 1'b0;
					end else begin
						take_root(r.removed_key, r.removed_tag);
						// drain down below a lowered capacity
						while (heap_used >= cap) take_root(dk, dt);
					end
				end
				if (inserting) add_entry(key, tag);
			end
			OP_POP: begin
				if (heap_used > 0) begin
					r.removed_valid = 1'b1;
					take_root(r.removed_key, r.removed_tag);
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < HEAP_DEPTH; i++) begin
					heap_key_q[i] = '0;
					heap_tag_q[i] = '0;
				end
				heap_used = 0;
			end
			default: ;
		endcase
		r.entry_count = heap_used[6:0];
		return r;
	endfunction

	// send one item after a random gap; prediction made at acceptance
	task automatic send_item(logic [1:0] op, logic [31:0] tag, logic [63:0] key);
		int gap;
		gap = stall_enable ? $urandom_range(0, 12) : 0;
		// valid drops only for a real gap, so back-to-back items keep it high
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {key, tag};
		do @(posedge clk); while (!s_tready);
		pending_removals.push_back(predict_removal(op, tag, key));
		item_count++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_removals.size() != 0) @(posedge clk);
		// the unit has finished sifting once its result went out; this only adds idle margin
		repeat (400) @(posedge clk);
	endtask

	task automatic write_capacity(logic [6:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_CAPACITY;
		pwdata  <= {25'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		capacity_reg = value;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// random key mixing full-range values with narrow pools so ties and reorderings happen often
	function automatic logic [63:0] rand_key();
		case ($urandom_range(0, 3))
			0: return {$urandom, $urandom};
			1: return 64'(($urandom_range(0, 15)));
			2: return {$urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom, 32'hFFFF_FFFF};
			default: return {$urandom, 32'd0};
		endcase
	endfunction

	// result checker and consumer stall, one drawn wait per result item
	always @(posedge clk) begin
		removal_t got, want;
		int out_wait;
		if (m_tvalid && m_tready) begin
			got.removed_valid = m_tuser[0];
			got.removed_tag   = m_tdata[31:0];
			got.removed_key   = m_tdata[95:32];
			got.entry_count   = m_tdata[102:96];
			result_count++;
			if (pending_removals.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result item %0h", got);
			end else begin
				want = pending_removals.pop_front();
				if (got !== want || m_tdata[103] !== 1'b0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result %0d: expected v=%0b tag=%h key=%h cnt=%0d, got v=%0b tag=%h key=%h cnt=%0d",
							result_count, want.removed_valid, want.removed_tag,
							want.removed_key, want.entry_count, got.removed_valid,
							got.removed_tag, got.removed_key, got.entry_count);
				end
			end
		end
		if (arst_n) begin
			if (m_tvalid && m_tready)
				out_wait = stall_enable ? $urandom_range(0, 12) : 0;
			else if (out_wait > 0)
				out_wait--;
			m_tready <= (out_wait == 0);
		end
	end

	// extremes of the fields, every operation and each corner
	task automatic test_directed();
		write_capacity(7'd3);
		send_item(OP_POP, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF); // pop on empty
		send_item(OP_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_INSERT, 32'h0000_0000, 64'h0);
		send_item(OP_INSERT, 32'hA5A5_5A5A, 64'h10);
		send_item(OP_INSERT, 32'h1234_5678, 64'h10); // full, equal-ish: root popped
		send_item(OP_INSERT, 32'h5555_AAAA, 64'h1);  // older than root: bounced
		send_item(OP_INSERT, 32'hAAAA_5555, 64'h10); // equal key to root
		send_item(OP_UNUSED, 32'hDEAD_BEEF, 64'h5);
		send_item(OP_POP, 32'h0, 64'h0);
		send_item(OP_POP, 32'h0, 64'h0);
		send_item(OP_POP, 32'h0, 64'h0);
		send_item(OP_POP, 32'h0, 64'h0);
		send_item(OP_INSERT, 32'h1, 64'h7);
		send_item(OP_INSERT, 32'h2, 64'h7);
		send_item(OP_CLEAR, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_POP, 32'h0, 64'h0);
		wait_drained();
		// capacity zero acts as one
		write_capacity(7'd0);
		send_item(OP_INSERT, 32'h11, 64'h20);
		send_item(OP_INSERT, 32'h22, 64'h30);
		send_item(OP_INSERT, 32'h33, 64'h5);
		send_item(OP_CLEAR, 32'h0, 64'h0);
		wait_drained();
	endtask

	// fill, then lower the capacity under the count and insert again
	task automatic test_lowered_capacity();
		write_capacity(7'd127); // above depth acts as depth
		for (int i = 0; i < 70; i++) send_item(OP_INSERT, $urandom, rand_key());
		wait_drained();
		write_capacity(7'd5);
		send_item(OP_INSERT, $urandom, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_INSERT, $urandom, rand_key());
		wait_drained();
		write_capacity(7'd64);
		send_item(OP_CLEAR, 32'h0, 64'h0);
		wait_drained();
	endtask

	// random phases at several capacities; inserts dominate to reach full heaps
	task automatic test_random();
		logic [6:0] caps [6];
		int pick;
		logic [1:0] op;
		caps = '{7'd1, 7'd2, 7'd7, 7'd33, 7'd64, 7'd100};
		for (int ph = 0; ph < 6; ph++) begin
			write_capacity(caps[ph]);
			stall_enable = (ph != 2);
			for (int i = 0; i < 180; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 65) op = OP_INSERT;
				else if (pick < 95) op = OP_POP;
				else if (pick < 98) op = OP_CLEAR;
				else op = OP_UNUSED;
				send_item(op, $urandom, rand_key());
				// hold off once until the unit has caught up
				if (ph == 3 && i == 90) begin
					s_tvalid <= 1'b0;
					do @(posedge clk); while (pending_removals.size() != 0);
				end
			end
			wait_drained();
		end
		stall_enable = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		heap_used = 0;
		capacity_reg = 7'd64;
		mismatch_count = 0; result_count = 0; item_count = 0;
		stall_enable = 1'b1;
		for (int i = 0; i < HEAP_DEPTH; i++) begin
			heap_key_q[i] = '0;
			heap_tag_q[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_lowered_capacity();
		test_random();
		wait_drained();
		$display("covered %0d items and %0d results over capacities 0 to 127,", item_count,
			result_count);
		$display("including evictions, bounced inserts, empty pops, clears and the unused code");
		if (mismatch_count == 0 && pending_removals.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire

/* bounded_min_heap_evicting_unit.f */
hw/rtl/bmhe_pkg.sv
hw/rtl/bmhe_ram.sv
hw/rtl/bmhe_dp.sv
hw/rtl/bmhe_ctrl.sv
hw/rtl/bounded_min_heap_evicting_unit.sv
test/testbench.sv
